@@ rtl/core/ec_projective_scalar_multiply_top_assert.svh @@
// assertion macros for the scalar multiply block
`ifndef EC_PROJECTIVE_SCALAR_MULTIPLY_TOP_ASSERT_SVH
`define EC_PROJECTIVE_SCALAR_MULTIPLY_TOP_ASSERT_SVH

// same-cycle implication
`define ECPSM_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ecpsm assertion failed");

// next-cycle implication
`define ECPSM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ecpsm assertion failed");

`endif

@@ rtl/core/ecpsm_pkg.sv @@
package ecpsm_pkg;

	localparam int FIELD_LIMBS = 4;
	localparam int LIMB_W = 64;
	localparam int FE_W = FIELD_LIMBS * LIMB_W;
	localparam int LIMB_CNT_W = (FIELD_LIMBS > 1) ? $clog2(FIELD_LIMBS) : 1;
	localparam int BIT_CNT_W = $clog2(FE_W);
	localparam int REG_AW = 5;
	localparam int NUM_REGS = 21;
	localparam int PC_W = 6;

	localparam logic [2:0] ACT_MOD = 3'd0;
	localparam logic [2:0] ACT_A = 3'd1;
	localparam logic [2:0] ACT_X = 3'd2;
	localparam logic [2:0] ACT_Y = 3'd3;
	localparam logic [2:0] ACT_Z = 3'd4;
	localparam logic [2:0] ACT_K = 3'd5;
	localparam logic [2:0] ACT_RUN = 3'd6;

	localparam logic [1:0] COORD_X = 2'd0;
	localparam logic [1:0] COORD_Z = 2'd2;

	typedef logic [REG_AW-1:0] reg_addr_t;

	// register file map
	localparam reg_addr_t R_A = 5'd0;
	localparam reg_addr_t R_BX = 5'd1;
	localparam reg_addr_t R_BY = 5'd2;
	localparam reg_addr_t R_BZ = 5'd3;
	localparam reg_addr_t R_AX = 5'd4;
	localparam reg_addr_t R_AY = 5'd5;
	localparam reg_addr_t R_AZ = 5'd6;
	localparam reg_addr_t R_RX = 5'd7;
	localparam reg_addr_t R_RY = 5'd8;
	localparam reg_addr_t R_RZ = 5'd9;
	localparam reg_addr_t T_XX = 5'd10;
	localparam reg_addr_t T_ZZ = 5'd11;
	localparam reg_addr_t T_W = 5'd12;
	localparam reg_addr_t T_S = 5'd13;
	localparam reg_addr_t T_SSS = 5'd14;
	localparam reg_addr_t T_R = 5'd15;
	localparam reg_addr_t T_RR = 5'd16;
	localparam reg_addr_t T_B = 5'd17;
	localparam reg_addr_t T_H = 5'd18;
	localparam reg_addr_t T_T = 5'd19;
	localparam reg_addr_t T_AA = 5'd20;
	localparam reg_addr_t T_Y1Z2 = 5'd10;
	localparam reg_addr_t T_X1Z2 = 5'd11;
	localparam reg_addr_t T_Z1Z2 = 5'd12;
	localparam reg_addr_t T_U = 5'd13;
	localparam reg_addr_t T_UU = 5'd14;
	localparam reg_addr_t T_V = 5'd15;
	localparam reg_addr_t T_VV = 5'd16;
	localparam reg_addr_t T_VVV = 5'd17;
	localparam reg_addr_t T_ARR = 5'd18;

	localparam logic [PC_W-1:0] UC_RED = 6'd0;
	localparam logic [PC_W-1:0] UC_CPY = 6'd4;
	localparam logic [PC_W-1:0] UC_DBL = 6'd7;
	localparam logic [PC_W-1:0] UC_ADD = 6'd32;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_CPY,
		OP_MUL,
		OP_RED
	} uop_t;

	typedef enum logic [1:0] {
		PROG_RED,
		PROG_CPY,
		PROG_DBL,
		PROG_ADD
	} prog_t;

	typedef struct packed {
		uop_t op;
		reg_addr_t dst;
		reg_addr_t src_a;
		reg_addr_t src_b;
		logic last;
	} uinstr_t;

	typedef struct packed {
		logic [2:0] action;
		logic [1:0] limb_index;
		logic [63:0] limb_value;
	} op_word_t;

	typedef struct packed {
		logic [1:0] coordinate;
		logic [1:0] out_limb_index;
		logic [63:0] out_limb_value;
		logic last;
	} res_word_t;

	typedef struct packed {
		logic load;
		logic k_init;
		logic k_shift;
		logic rd_en;
		reg_addr_t rd_addr_a;
		reg_addr_t rd_addr_b;
		logic alu_wr;
		uop_t alu_op;
		logic mul_start;
		logic mul_red;
		logic mul_wr;
		reg_addr_t wr_addr;
		logic res_load;
		logic [1:0] res_coord;
		logic [LIMB_CNT_W-1:0] res_limb;
		logic res_last;
		logic res_zero;
	} dp_cmd_t;

	typedef struct packed {
		logic p_zero;
		logic k_bit;
		logic k_more;
		logic mul_busy;
		logic res_free;
	} dp_status_t;

	// reduce, copy, dbl-2007-bl, add-1998-cmo-2
	function automatic uinstr_t ucode(input logic [PC_W-1:0] pc);
		uinstr_t u;
		case (pc)
			6'd0: u = '{OP_RED, R_A, R_A, R_A, 1'b0};
			6'd1: u = '{OP_RED, R_RX, R_BX, R_BX, 1'b0};
			6'd2: u = '{OP_RED, R_RY, R_BY, R_BY, 1'b0};
			6'd3: u = '{OP_RED, R_RZ, R_BZ, R_BZ, 1'b1};
			6'd4: u = '{OP_CPY, R_AX, R_RX, R_RX, 1'b0};
			6'd5: u = '{OP_CPY, R_AY, R_RY, R_RY, 1'b0};
			6'd6: u = '{OP_CPY, R_AZ, R_RZ, R_RZ, 1'b1};
			6'd7: u = '{OP_MUL, T_XX, R_RX, R_RX, 1'b0};
			6'd8: u = '{OP_MUL, T_ZZ, R_RZ, R_RZ, 1'b0};
			6'd9: u = '{OP_ADD, T_T, T_XX, T_XX, 1'b0};
			6'd10: u = '{OP_ADD, T_T, T_T, T_XX, 1'b0};
			6'd11: u = '{OP_MUL, T_W, R_A, T_ZZ, 1'b0};
			6'd12: u = '{OP_ADD, T_W, T_W, T_T, 1'b0};
			6'd13: u = '{OP_MUL, T_S, R_RY, R_RZ, 1'b0};
			6'd14: u = '{OP_ADD, T_S, T_S, T_S, 1'b0};
			6'd15: u = '{OP_MUL, T_SSS, T_S, T_S, 1'b0};
			6'd16: u = '{OP_MUL, T_SSS, T_SSS, T_S, 1'b0};
			6'd17: u = '{OP_MUL, T_R, R_RY, T_S, 1'b0};
			6'd18: u = '{OP_MUL, T_RR, T_R, T_R, 1'b0};
			6'd19: u = '{OP_ADD, T_T, T_R, R_RX, 1'b0};
			6'd20: u = '{OP_MUL, T_T, T_T, T_T, 1'b0};
			6'd21: u = '{OP_SUB, T_T, T_T, T_XX, 1'b0};
			6'd22: u = '{OP_SUB, T_B, T_T, T_RR, 1'b0};
			6'd23: u = '{OP_MUL, T_H, T_W, T_W, 1'b0};
			6'd24: u = '{OP_SUB, T_H, T_H, T_B, 1'b0};
			6'd25: u = '{OP_SUB, T_H, T_H, T_B, 1'b0};
			6'd26: u = '{OP_MUL, R_RX, T_H, T_S, 1'b0};
			6'd27: u = '{OP_SUB, T_T, T_B, T_H, 1'b0};
			6'd28: u = '{OP_MUL, T_T, T_T, T_W, 1'b0};
			6'd29: u = '{OP_SUB, T_T, T_T, T_RR, 1'b0};
			6'd30: u = '{OP_SUB, R_RY, T_T, T_RR, 1'b0};
			6'd31: u = '{OP_CPY, R_RZ, T_SSS, T_SSS, 1'b1};
			6'd32: u = '{OP_MUL, T_Y1Z2, R_AY, R_RZ, 1'b0};
			6'd33: u = '{OP_MUL, T_X1Z2, R_AX, R_RZ, 1'b0};
			6'd34: u = '{OP_MUL, T_Z1Z2, R_AZ, R_RZ, 1'b0};
			6'd35: u = '{OP_MUL, T_T, R_RY, R_AZ, 1'b0};
			6'd36: u = '{OP_SUB, T_U, T_T, T_Y1Z2, 1'b0};
			6'd37: u = '{OP_MUL, T_UU, T_U, T_U, 1'b0};
			6'd38: u = '{OP_MUL, T_T, R_RX, R_AZ, 1'b0};
			6'd39: u = '{OP_SUB, T_V, T_T, T_X1Z2, 1'b0};
			6'd40: u = '{OP_MUL, T_VV, T_V, T_V, 1'b0};
			6'd41: u = '{OP_MUL, T_VVV, T_V, T_VV, 1'b0};
			6'd42: u = '{OP_MUL, T_ARR, T_VV, T_X1Z2, 1'b0};
			6'd43: u = '{OP_MUL, T_AA, T_UU, T_Z1Z2, 1'b0};
			6'd44: u = '{OP_SUB, T_AA, T_AA, T_VVV, 1'b0};
			6'd45: u = '{OP_SUB, T_AA, T_AA, T_ARR, 1'b0};
			6'd46: u = '{OP_SUB, T_AA, T_AA, T_ARR, 1'b0};
			6'd47: u = '{OP_MUL, R_AX, T_V, T_AA, 1'b0};
			6'd48: u = '{OP_SUB, T_T, T_ARR, T_AA, 1'b0};
			6'd49: u = '{OP_MUL, T_T, T_U, T_T, 1'b0};
			6'd50: u = '{OP_MUL, T_AA, T_VVV, T_Y1Z2, 1'b0};
			6'd51: u = '{OP_SUB, R_AY, T_T, T_AA, 1'b0};
			6'd52: u = '{OP_MUL, R_AZ, T_VVV, T_Z1Z2, 1'b1};
			default: u = '{OP_CPY, T_T, T_T, T_T, 1'b1};
		endcase
		return u;
	endfunction

endpackage

@@ rtl/core/ecpsm_datapath.sv @@
module ecpsm_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ecpsm_pkg::op_word_t   op_word,
	input  ecpsm_pkg::dp_cmd_t    cmd,
	output ecpsm_pkg::dp_status_t status,
	output logic                  res_valid,
	input  logic                  res_ready,
	output ecpsm_pkg::res_word_t  res_word
);

	localparam int W = ecpsm_pkg::FE_W;
	localparam int NL = ecpsm_pkg::FIELD_LIMBS;
	localparam int LW = ecpsm_pkg::LIMB_W;
	localparam int BW = ecpsm_pkg::BIT_CNT_W;

	function automatic logic [W-1:0] fadd(input logic [W-1:0] x, input logic [W-1:0] y,
		input logic [W-1:0] p);
		logic [W:0] s;
		logic [W+1:0] d;
		s = {1'b0, x} + {1'b0, y};
		d = {1'b0, s} - {2'b00, p};
		return d[W+1] ? s[W-1:0] : d[W-1:0];
	endfunction

	function automatic logic [W-1:0] fsub(input logic [W-1:0] x, input logic [W-1:0] y,
		input logic [W-1:0] p);
		logic [W:0] d;
		d = {1'b0, x} - {1'b0, y};
		return d[W] ? (d[W-1:0] + p) : d[W-1:0];
	endfunction

	logic [W-1:0] mem [ecpsm_pkg::NUM_REGS];
	logic [W-1:0] p_q, k_q, kw_q;
	logic [W-1:0] rd_a_q, rd_b_q;
	logic [W-1:0] mul_a_q, mul_b_q, mul_r_q;
	logic [BW-1:0] mul_cnt_q;
	logic mul_ph_q, mul_busy_q;
	logic res_valid_q;
	ecpsm_pkg::res_word_t res_word_q;

	logic limb_ok, mem_ld, wr_en;
	logic [NL-1:0] limb_mask, wr_mask;
	ecpsm_pkg::reg_addr_t ld_addr, wr_addr;
	logic [W-1:0] wr_data, alu_res, mul_y, mul_sum, one;

	always_comb begin
		limb_ok = 32'(op_word.limb_index) < NL;
		for (int l = 0; l < NL; l++) begin
			limb_mask[l] = 32'(op_word.limb_index) == l;
		end
		mem_ld = 1'b1;
		ld_addr = ecpsm_pkg::R_A;
		case (op_word.action)
			ecpsm_pkg::ACT_A: ld_addr = ecpsm_pkg::R_A;
			ecpsm_pkg::ACT_X: ld_addr = ecpsm_pkg::R_BX;
			ecpsm_pkg::ACT_Y: ld_addr = ecpsm_pkg::R_BY;
			ecpsm_pkg::ACT_Z: ld_addr = ecpsm_pkg::R_BZ;
			default: mem_ld = 1'b0;
		endcase
	end

	always_comb begin
		case (cmd.alu_op)
			ecpsm_pkg::OP_ADD: alu_res = fadd(rd_a_q, rd_b_q, p_q);
			ecpsm_pkg::OP_SUB: alu_res = fsub(rd_a_q, rd_b_q, p_q);
			default: alu_res = rd_a_q;
		endcase
	end

	assign one = {{(W-1){1'b0}}, |p_q[W-1:1]};
	assign mul_y = mul_ph_q ? mul_a_q : mul_r_q;
	assign mul_sum = fadd(mul_r_q, mul_y, p_q);

	assign wr_en = (cmd.load && mem_ld && limb_ok) || cmd.alu_wr || cmd.mul_wr;
	assign wr_mask = cmd.load ? limb_mask : {NL{1'b1}};
	assign wr_addr = cmd.load ? ld_addr : cmd.wr_addr;
	assign wr_data = cmd.load ? {NL{op_word.limb_value}} : (cmd.mul_wr ? mul_r_q : alu_res);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int l = 0; l < NL; l++) begin
				if (wr_mask[l]) begin
					mem[wr_addr][l*LW +: LW] <= wr_data[l*LW +: LW];
				end
			end
		end
		if (cmd.rd_en) begin
			rd_a_q <= mem[cmd.rd_addr_a];
			rd_b_q <= mem[cmd.rd_addr_b];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && limb_ok) begin
			for (int l = 0; l < NL; l++) begin
				if (limb_mask[l] && op_word.action == ecpsm_pkg::ACT_MOD) begin
					p_q[l*LW +: LW] <= op_word.limb_value;
				end
				if (limb_mask[l] && op_word.action == ecpsm_pkg::ACT_K) begin
					k_q[l*LW +: LW] <= op_word.limb_value;
				end
			end
		end
		if (cmd.k_init) begin
			kw_q <= k_q;
		end else if (cmd.k_shift) begin
			kw_q <= {1'b0, kw_q[W-1:1]};
		end
	end

	// bit-serial interleaved modular multiply, msb first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mul_ph_q <= 1'b0;
			mul_cnt_q <= '0;
		end else if (cmd.mul_start) begin
			mul_busy_q <= 1'b1;
			mul_ph_q <= 1'b0;
			mul_cnt_q <= '0;
		end else if (mul_busy_q) begin
			if (!mul_ph_q && mul_b_q[W-1]) begin
				mul_ph_q <= 1'b1;
			end else begin
				mul_ph_q <= 1'b0;
				mul_cnt_q <= mul_cnt_q + 1'b1;
				if (mul_cnt_q == BW'(W - 1)) begin
					mul_busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			mul_a_q <= cmd.mul_red ? one : rd_a_q;
			mul_b_q <= cmd.mul_red ? rd_a_q : rd_b_q;
			mul_r_q <= '0;
		end else if (mul_busy_q) begin
			mul_r_q <= mul_sum;
			if (mul_ph_q || !mul_b_q[W-1]) begin
				mul_b_q <= {mul_b_q[W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_word_q.coordinate <= cmd.res_coord;
			res_word_q.out_limb_index <= 2'(cmd.res_limb);
			res_word_q.out_limb_value <= cmd.res_zero ? '0 : rd_a_q[cmd.res_limb*LW +: LW];
			res_word_q.last <= cmd.res_last;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word = res_word_q;

	assign status.p_zero = p_q == '0;
	assign status.k_bit = kw_q[0];
	assign status.k_more = |kw_q[W-1:1];
	assign status.mul_busy = mul_busy_q;
	assign status.res_free = !res_valid_q || res_ready;

endmodule

@@ rtl/core/ecpsm_ctrl.sv @@
module ecpsm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  op_valid,
	output logic                  op_ready,
	input  ecpsm_pkg::op_word_t   op_word,
	output ecpsm_pkg::dp_cmd_t    cmd,
	input  ecpsm_pkg::dp_status_t status
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_RD    = 7'b0000010,
		ST_OP    = 7'b0000100,
		ST_MUL   = 7'b0001000,
		ST_BIT   = 7'b0010000,
		ST_EMRD  = 7'b0100000,
		ST_EMOUT = 7'b1000000
	} ctrl_state_t;

	localparam int LCW = ecpsm_pkg::LIMB_CNT_W;

	ctrl_state_t state_q, state_d;
	logic [ecpsm_pkg::PC_W-1:0] pc_q, pc_d;
	ecpsm_pkg::prog_t prog_q, prog_d;
	logic inf_q, inf_d;
	logic [1:0] coord_q, coord_d;
	logic [LCW-1:0] limb_q, limb_d;
	ecpsm_pkg::uinstr_t ui;
	logic instr_done, accept;

	assign ui = ecpsm_pkg::ucode(pc_q);
	assign op_ready = state_q == ST_IDLE;
	assign accept = op_valid && op_ready;

	always_comb begin
		state_d = state_q;
		pc_d = pc_q;
		prog_d = prog_q;
		inf_d = inf_q;
		coord_d = coord_q;
		limb_d = limb_q;
		cmd = '0;
		instr_done = 1'b0;
		cmd.rd_addr_a = ui.src_a;
		cmd.rd_addr_b = ui.src_b;
		cmd.wr_addr = ui.dst;
		cmd.alu_op = ui.op;
		cmd.res_coord = coord_q;
		cmd.res_limb = limb_q;
		cmd.res_zero = inf_q;
		cmd.res_last = coord_q == ecpsm_pkg::COORD_Z && limb_q == LCW'(ecpsm_pkg::FIELD_LIMBS - 1);
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = op_word.action != ecpsm_pkg::ACT_RUN;
					if (op_word.action == ecpsm_pkg::ACT_RUN) begin
						cmd.k_init = 1'b1;
						inf_d = 1'b1;
						coord_d = ecpsm_pkg::COORD_X;
						limb_d = '0;
						if (status.p_zero) begin
							state_d = ST_EMRD;
						end else begin
							pc_d = ecpsm_pkg::UC_RED;
							prog_d = ecpsm_pkg::PROG_RED;
							state_d = ST_RD;
						end
					end
				end
			end
			ST_RD: begin
				cmd.rd_en = 1'b1;
				state_d = ST_OP;
			end
			ST_OP: begin
				case (ui.op)
					ecpsm_pkg::OP_MUL, ecpsm_pkg::OP_RED: begin
						cmd.mul_start = 1'b1;
						cmd.mul_red = ui.op == ecpsm_pkg::OP_RED;
						state_d = ST_MUL;
					end
					default: begin
						cmd.alu_wr = 1'b1;
						instr_done = 1'b1;
					end
				endcase
			end
			ST_MUL: begin
				if (!status.mul_busy) begin
					cmd.mul_wr = 1'b1;
					instr_done = 1'b1;
				end
			end
			ST_BIT: begin
				if (status.k_bit) begin
					state_d = ST_RD;
					if (inf_q) begin
						inf_d = 1'b0;
						pc_d = ecpsm_pkg::UC_CPY;
						prog_d = ecpsm_pkg::PROG_CPY;
					end else begin
						pc_d = ecpsm_pkg::UC_ADD;
						prog_d = ecpsm_pkg::PROG_ADD;
					end
				end else if (status.k_more) begin
					pc_d = ecpsm_pkg::UC_DBL;
					prog_d = ecpsm_pkg::PROG_DBL;
					state_d = ST_RD;
				end else begin
					state_d = ST_EMRD;
				end
			end
			ST_EMRD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_addr_a = ecpsm_pkg::R_AX + ecpsm_pkg::REG_AW'(coord_q);
				state_d = ST_EMOUT;
			end
			ST_EMOUT: begin
				if (status.res_free) begin
					cmd.res_load = 1'b1;
					limb_d = limb_q + 1'b1;
					if (limb_q == LCW'(ecpsm_pkg::FIELD_LIMBS - 1)) begin
						limb_d = '0;
						coord_d = coord_q + 1'b1;
						state_d = (coord_q == ecpsm_pkg::COORD_Z) ? ST_IDLE : ST_EMRD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase

		if (instr_done) begin
			if (!ui.last) begin
				pc_d = pc_q + 1'b1;
				state_d = ST_RD;
			end else begin
				case (prog_q)
					ecpsm_pkg::PROG_RED: state_d = ST_BIT;
					ecpsm_pkg::PROG_DBL: begin
						cmd.k_shift = 1'b1;
						state_d = ST_BIT;
					end
					default: begin
						if (status.k_more) begin
							pc_d = ecpsm_pkg::UC_DBL;
							prog_d = ecpsm_pkg::PROG_DBL;
							state_d = ST_RD;
						end else begin
							state_d = ST_EMRD;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
			prog_q <= ecpsm_pkg::PROG_RED;
			inf_q <= 1'b1;
			coord_q <= '0;
			limb_q <= '0;
		end else begin
			state_q <= state_d;
			pc_q <= pc_d;
			prog_q <= prog_d;
			inf_q <= inf_d;
			coord_q <= coord_d;
			limb_q <= limb_d;
		end
	end

endmodule

@@ rtl/core/ec_projective_scalar_multiply_top.sv @@
// load words are taken back to back, one per cycle, while no run is active
// a run holds off the input until its last result word is loaded: up to 26 multiplies
// per scalar bit (12 to double, 14 to add), each done by the bit-serial modular multiplier
// twelve result words follow, one per cycle while ready within a coordinate, after a register read per coordinate
// asynchronous active-low reset clears control; loaded operands are undefined
module ec_projective_scalar_multiply_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 op_valid,
	output logic                 op_ready,
	input  ecpsm_pkg::op_word_t  op_word,
	output logic                 res_valid,
	input  logic                 res_ready,
	output ecpsm_pkg::res_word_t res_word
);

	ecpsm_pkg::dp_cmd_t cmd;
	ecpsm_pkg::dp_status_t status;

	ecpsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.op_word  (op_word),
		.cmd      (cmd),
		.status   (status)
	);

	ecpsm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_word   (op_word),
		.cmd       (cmd),
		.status    (status),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word)
	);

endmodule

@@ rtl/core/ecpsm_checker.sv @@
`include "ec_projective_scalar_multiply_top_assert.svh"

module ecpsm_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 op_valid,
	input logic                 op_ready,
	input ecpsm_pkg::op_word_t  op_word,
	input logic                 res_valid,
	input logic                 res_ready,
	input ecpsm_pkg::res_word_t res_word
);

	logic run_taken, last_slot;

	assign run_taken = op_valid && op_ready && op_word.action == ecpsm_pkg::ACT_RUN;
	assign last_slot = res_word.coordinate == ecpsm_pkg::COORD_Z &&
		res_word.out_limb_index == 2'(ecpsm_pkg::FIELD_LIMBS - 1);

	`ECPSM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_word))
	`ECPSM_ASSERT_SAME(a_idle_only_last, op_ready && res_valid, res_word.last)
	`ECPSM_ASSERT_NEXT(a_run_busy, run_taken, !op_ready)
	`ECPSM_ASSERT_SAME(a_coord_range, res_valid, res_word.coordinate != 2'd3)
	`ECPSM_ASSERT_SAME(a_last_pos, res_valid && res_word.last, last_slot)

endmodule

bind ec_projective_scalar_multiply_top ecpsm_checker u_ecpsm_checker (.*);
